// File: src/json_string_unescape_core_macros.svh
// ----------------------------------------------------------------------------
// json_string_unescape_core_macros.svh
// Assertion helpers shared by the JSON string unescape modules.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_CORE_MACROS_SVH
`define JSON_STRING_UNESCAPE_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define JSU_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define JSU_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared across the JSON string unescape block.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // One decoded group: up to three result beats caused by one input beat
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] cnt_m1;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } jsu_group_t;

  // Queue occupancy flags seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } jsu_q_status_t;

endpackage

// File: src/jsu_char_if.sv
// ----------------------------------------------------------------------------
// jsu_char_if
// Input channel: one character byte or an end-of-input mark per beat.
// ----------------------------------------------------------------------------
interface jsu_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       at_end;

  modport source (output valid, output in_byte, output at_end, input ready);
  modport sink   (input valid, input in_byte, input at_end, output ready);
endinterface

// File: src/jsu_result_if.sv
// ----------------------------------------------------------------------------
// jsu_result_if
// Output channel: one decoded byte, completion or error per beat.
// ----------------------------------------------------------------------------
interface jsu_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

// File: src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts input beats, tracks string/escape state and turns each beat into
// a group of zero to three result beats pushed into the queue.
// ----------------------------------------------------------------------------
`include "json_string_unescape_core_macros.svh"

module jsu_front (
  input  logic                   clk,
  input  logic                   rst,
  jsu_char_if.sink               chars,
  input  jsu_pkg::jsu_q_status_t q_status,
  output logic                   push,
  output jsu_pkg::jsu_group_t    group
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEXT = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [1:0]  hex_seen;
  logic [1:0]  hex_seen_next;
  logic [11:0] code_point;
  logic [11:0] code_point_next;

  logic        accept;
  logic [7:0]  c;
  logic [4:0]  hex_val;
  logic [15:0] cp_full;

  assign chars.ready = !q_status.full;
  assign accept      = chars.valid && chars.ready;
  assign c           = chars.in_byte;
  assign cp_full     = {code_point, hex_val[3:0]};

  // Convert a hex digit to its value; bit 4 flags a non-hex byte
  always_comb begin
    hex_val = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      hex_val = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      hex_val = 5'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      hex_val = 5'(c - 8'h57);
    end
  end

  // Classify the beat and build its result group
  always_comb begin
    mode_next       = mode;
    hex_seen_next   = hex_seen;
    code_point_next = code_point;
    push            = 1'b0;
    group.kind      = jsu_pkg::KIND_DATA;
    group.cnt_m1    = 2'd0;
    group.b0        = c;
    group.b1        = 8'h00;
    group.b2        = 8'h00;

    if (chars.at_end) begin
      push            = 1'b1;
      group.kind      = jsu_pkg::KIND_ERROR;
      group.b0        = 8'h00;
      mode_next       = MODE_IDLE;
      hex_seen_next   = 2'd0;
      code_point_next = 12'h000;
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (c == CH_QUOTE) begin
            mode_next = MODE_TEXT;
          end else begin
            push            = 1'b1;
            group.kind      = jsu_pkg::KIND_ERROR;
            group.b0        = 8'h00;
            hex_seen_next   = 2'd0;
            code_point_next = 12'h000;
          end
        end
        MODE_TEXT: begin
          if (c == CH_QUOTE) begin
            push       = 1'b1;
            group.kind = jsu_pkg::KIND_DONE;
            group.b0   = 8'h00;
            mode_next  = MODE_IDLE;
          end else if (c == CH_BSL) begin
            mode_next = MODE_ESC;
          end else begin
            push = 1'b1;
          end
        end
        MODE_ESC: begin
          push      = 1'b1;
          mode_next = MODE_TEXT;
          case (c)
            CH_QUOTE: group.b0 = 8'h22;
            CH_BSL:   group.b0 = 8'h5c;
            CH_SLASH: group.b0 = 8'h2f;
            CH_B:     group.b0 = 8'h08;
            CH_F:     group.b0 = 8'h0c;
            CH_N:     group.b0 = 8'h0a;
            CH_R:     group.b0 = 8'h0d;
            CH_T:     group.b0 = 8'h09;
            CH_U: begin
              push            = 1'b0;
              mode_next       = MODE_HEX;
              hex_seen_next   = 2'd0;
              code_point_next = 12'h000;
            end
            default: begin
              group.kind      = jsu_pkg::KIND_ERROR;
              group.b0        = 8'h00;
              mode_next       = MODE_IDLE;
              hex_seen_next   = 2'd0;
              code_point_next = 12'h000;
            end
          endcase
        end
        default: begin
          if (hex_val[4]) begin
            push            = 1'b1;
            group.kind      = jsu_pkg::KIND_ERROR;
            group.b0        = 8'h00;
            mode_next       = MODE_IDLE;
            hex_seen_next   = 2'd0;
            code_point_next = 12'h000;
          end else if (hex_seen != 2'd3) begin
            hex_seen_next   = hex_seen + 2'd1;
            code_point_next = {code_point[7:0], hex_val[3:0]};
          end else begin
            // Fourth digit: encode the code point as UTF-8
            push            = 1'b1;
            mode_next       = MODE_TEXT;
            hex_seen_next   = 2'd0;
            code_point_next = 12'h000;
            if (cp_full <= 16'h007f) begin
              group.b0 = cp_full[7:0];
            end else if (cp_full <= 16'h07ff) begin
              group.cnt_m1 = 2'd1;
              group.b0     = 8'hc0 | {3'b000, cp_full[10:6]};
              group.b1     = 8'h80 | {2'b00, cp_full[5:0]};
            end else begin
              group.cnt_m1 = 2'd2;
              group.b0     = 8'he0 | {4'h0, cp_full[15:12]};
              group.b1     = 8'h80 | {2'b00, cp_full[11:6]};
              group.b2     = 8'h80 | {2'b00, cp_full[5:0]};
            end
          end
        end
      endcase
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_seen   <= 2'd0;
      code_point <= 12'h000;
    end else if (accept) begin
      mode       <= mode_next;
      hex_seen   <= hex_seen_next;
      code_point <= code_point_next;
    end
  end

  // Hex digit count only moves while collecting a \u escape
  `JSU_ASSERT_NOW(a_hex_seen_mode, clk, rst, hex_seen != 2'd0, mode == MODE_HEX, "hex count outside hex mode")

  // A drop to idle on an accepted beat always reported a result
  `JSU_ASSERT_NEXT(a_idle_pushed, clk, rst, accept && mode != MODE_IDLE && mode_next == MODE_IDLE, $past(push), "return to idle without result")

endmodule

// File: src/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short register queue of result groups between front and back.
// ----------------------------------------------------------------------------
`include "json_string_unescape_core_macros.svh"

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  jsu_pkg::jsu_group_t     push_group,
  input  logic                    pop,
  output jsu_pkg::jsu_group_t     head,
  output jsu_pkg::jsu_q_status_t  status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  jsu_pkg::jsu_group_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  `JSU_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_FULL, "queue count overflow")

  `JSU_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !status.empty, "pop from empty queue")

endmodule

// File: src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Drains result groups one beat at a time into a registered output stage.
// ----------------------------------------------------------------------------
`include "json_string_unescape_core_macros.svh"

module jsu_back (
  input  logic                   clk,
  input  logic                   rst,
  input  jsu_pkg::jsu_group_t    head,
  input  jsu_pkg::jsu_q_status_t q_status,
  output logic                   pop,
  jsu_result_if.source           results
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  assign load    = !q_status.empty && (!results.valid || results.ready);
  assign at_last = (idx == head.cnt_m1);
  assign pop     = load && at_last;

  // Pick the current beat of the head group
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  // Step through the group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

  // Hold the output beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.out_byte <= sel_byte;
      results.kind     <= head.kind;
      results.last     <= at_last;
    end
  end

  `JSU_ASSERT_NOW(a_status_last, clk, rst, results.valid && results.kind != jsu_pkg::KIND_DATA, results.last, "status beat not marked last")

  `JSU_ASSERT_NOW(a_idx_bound, clk, rst, !q_status.empty, idx <= head.cnt_m1, "beat index past group end")

endmodule

// File: src/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Decodes a quoted JSON string, byte by byte, into raw and UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                  | meaning
//  chars    | in  | in_byte, at_end         | one character or end mark a beat
//  results  | out | out_byte, kind, last    | data byte, done or error a beat
//
//  One input beat per cycle while the queue has room; results pass through the queue and the output register.
//  A \u escape gives up to three output beats; the back end sends one a cycle while results are taken.
//  The group queue (DEPTH entries) absorbs that burst; chars stalls only when full.
//  rst is synchronous: decoder returns to waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_core #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  jsu_char_if.sink      chars,
  jsu_result_if.source  results
);

  jsu_pkg::jsu_group_t    push_group;
  jsu_pkg::jsu_group_t    head;
  jsu_pkg::jsu_q_status_t q_status;
  logic                   push;
  logic                   push_acc;
  logic                   pop;

  // Only queue groups for beats that were really taken
  assign push_acc = push && chars.valid && chars.ready;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars),
    .q_status (q_status),
    .push     (push),
    .group    (push_group)
  );

  jsu_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push_acc),
    .push_group (push_group),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .results  (results)
  );

endmodule

// File: tb/tb_json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_core
// Feeds quoted JSON strings, broken strings and noise into the unescape core.
// Each result beat is checked against a cycle-free decoder kept beside the
// block. Both channels idle at random in bursts, with quiet stretches.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS    = 500;
  localparam int TAIL_ITEMS   = 40;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0c;
  localparam logic [7:0] CTL_LF    = 8'h0a;
  localparam logic [7:0] CTL_CR    = 8'h0d;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // Decoder states
  localparam logic [1:0] SCAN_QUOTE  = 2'd0;
  localparam logic [1:0] SCAN_TEXT   = 2'd1;
  localparam logic [1:0] SCAN_ESCAPE = 2'd2;
  localparam logic [1:0] SCAN_HEX    = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } char_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } result_beat_t;

  logic clk;
  logic rst;

  jsu_char_if   chars();
  jsu_result_if results();

  json_string_unescape_core dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  char_beat_t   pending[$];
  result_beat_t decoded_beats[$];
  char_beat_t   next_char;
  result_beat_t got_beat;
  result_beat_t want_beat;

  // Decoder state
  logic [1:0]   scan_mode;
  logic [1:0]   hex_count;
  logic [15:0]  code_pt;

  int mismatches;
  int send_gap;
  int take_gap;
  int idle_cycles;
  int phase_left;
  bit calm;

  // --------------------------------------------------------------------------
  // Decoder
  // --------------------------------------------------------------------------
  function automatic void push_beat(input logic [7:0] b, input logic [1:0] k,
                                    input logic l);
    result_beat_t r;
    r.out_byte = b;
    r.kind     = k;
    r.last     = l;
    decoded_beats.insert(decoded_beats.size(), r);
  endfunction

  function automatic void decode_fault();
    scan_mode = SCAN_QUOTE;
    hex_count = '0;
    code_pt   = '0;
    push_beat(8'h00, jsu_pkg::KIND_ERROR, 1'b1);
  endfunction

  function automatic void unescape_step(input logic [7:0] c, input logic at_end);
    logic [3:0]  nib;
    logic [15:0] cp;
    if (at_end) begin
      decode_fault();
      return;
    end
    case (scan_mode)
      SCAN_QUOTE: begin
        if (c != CH_QUOTE) decode_fault();
        else scan_mode = SCAN_TEXT;
      end
      SCAN_TEXT: begin
        if (c == CH_QUOTE) begin
          scan_mode = SCAN_QUOTE;
          push_beat(8'h00, jsu_pkg::KIND_DONE, 1'b1);
        end else if (c == CH_BSLASH) begin
          scan_mode = SCAN_ESCAPE;
        end else begin
          push_beat(c, jsu_pkg::KIND_DATA, 1'b1);
        end
      end
      SCAN_ESCAPE: begin
        scan_mode = SCAN_TEXT;
        case (c)
          CH_QUOTE:  push_beat(CH_QUOTE, jsu_pkg::KIND_DATA, 1'b1);
          CH_BSLASH: push_beat(CH_BSLASH, jsu_pkg::KIND_DATA, 1'b1);
          CH_SLASH:  push_beat(CH_SLASH, jsu_pkg::KIND_DATA, 1'b1);
          CH_B:      push_beat(CTL_BS, jsu_pkg::KIND_DATA, 1'b1);
          CH_F:      push_beat(CTL_FF, jsu_pkg::KIND_DATA, 1'b1);
          CH_N:      push_beat(CTL_LF, jsu_pkg::KIND_DATA, 1'b1);
          CH_R:      push_beat(CTL_CR, jsu_pkg::KIND_DATA, 1'b1);
          CH_T:      push_beat(CTL_TAB, jsu_pkg::KIND_DATA, 1'b1);
          CH_U: begin
            scan_mode = SCAN_HEX;
            hex_count = '0;
            code_pt   = '0;
          end
          default:   decode_fault();
        endcase
      end
      default: begin
        if (c inside {[CH_0:CH_9]}) nib = 4'(c - CH_0);
        else if (c inside {[CH_UA:CH_UF]}) nib = 4'(c - CH_UA + 8'd10);
        else if (c inside {[CH_LA:CH_LF]}) nib = 4'(c - CH_LA + 8'd10);
        else begin
          decode_fault();
          return;
        end
        cp      = {code_pt[11:0], nib};
        code_pt = cp;
        if (hex_count != 2'd3) begin
          hex_count = hex_count + 2'd1;
          return;
        end
        // Fourth digit: emit the code point as UTF-8
        hex_count = '0;
        code_pt   = '0;
        scan_mode = SCAN_TEXT;
        if (cp <= 16'h007f) begin
          push_beat(cp[7:0], jsu_pkg::KIND_DATA, 1'b1);
        end else if (cp <= 16'h07ff) begin
          push_beat({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, 1'b0);
          push_beat({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 1'b1);
        end else begin
          push_beat({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, 1'b0);
          push_beat({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, 1'b0);
          push_beat({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, 1'b1);
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return CH_0 + 8'(nib);
    if ($urandom_range(0, 1) == 0) return CH_UA + 8'(nib) - 8'd10;
    return CH_LA + 8'(nib) - 8'd10;
  endfunction

  task automatic push_char(input logic [7:0] b);
    char_beat_t cb;
    cb.ch     = b;
    cb.at_end = 1'b0;
    pending.insert(pending.size(), cb);
  endtask

  task automatic push_end();
    char_beat_t cb;
    cb.ch     = 8'($urandom_range(0, 255));
    cb.at_end = 1'b1;
    pending.insert(pending.size(), cb);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // One quoted string of random pieces; a broken one stops at a fault
  task automatic push_string(input bit broken);
    int          pieces;
    int          fault_at;
    logic [7:0]  b;
    logic [15:0] cp;
    pieces   = $urandom_range(0, 10);
    fault_at = $urandom_range(0, pieces);
    push_char(CH_QUOTE);
    for (int i = 0; i <= pieces; i++) begin
      if (broken && i == fault_at) begin
        case ($urandom_range(0, 2))
          0: push_end();
          1: begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                             CH_R, CH_T, CH_U});
            push_char(CH_BSLASH);
            push_char(b);
          end
          default: begin
            push_char(CH_BSLASH);
            push_char(CH_U);
            repeat ($urandom_range(0, 3)) push_char(hex_char(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255));
            while (b inside {[CH_0:CH_9], [CH_UA:CH_UF], [CH_LA:CH_LF]});
            push_char(b);
          end
        endcase
        return;
      end
      if (i == pieces) break;
      case ($urandom_range(0, 5))
        3: begin
          push_char(CH_BSLASH);
          case ($urandom_range(0, 7))
            0: push_char(CH_QUOTE);
            1: push_char(CH_BSLASH);
            2: push_char(CH_SLASH);
            3: push_char(CH_B);
            4: push_char(CH_F);
            5: push_char(CH_N);
            6: push_char(CH_R);
            default: push_char(CH_T);
          endcase
        end
        4, 5: begin
          case ($urandom_range(0, 3))
            0: cp = 16'($urandom_range(0, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
            default: begin
              case ($urandom_range(0, 5))
                0: cp = 16'h0000;
                1: cp = 16'h007f;
                2: cp = 16'h0080;
                3: cp = 16'h07ff;
                4: cp = 16'h0800;
                default: cp = 16'hffff;
              endcase
            end
          endcase
          push_char(CH_BSLASH);
          push_char(CH_U);
          push_char(hex_char(cp[15:12]));
          push_char(hex_char(cp[11:8]));
          push_char(hex_char(cp[7:4]));
          push_char(hex_char(cp[3:0]));
        end
        default: begin
          do b = 8'($urandom_range(0, 255));
          while (b inside {CH_QUOTE, CH_BSLASH});
          push_char(b);
        end
      endcase
    end
    push_char(CH_QUOTE);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // --------------------------------------------------------------------------
  // Quiet stretches: no idling on either side while calm is set
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      phase_left <= 30;
      calm       <= 1'b0;
    end else if (phase_left == 0) begin
      phase_left <= $urandom_range(20, 80);
      calm       <= ($urandom_range(0, 2) == 0);
    end else begin
      phase_left <= phase_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Character driver: predict on each accepted beat, then present the next
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      chars.valid   <= 1'b0;
      chars.in_byte <= 8'h00;
      chars.at_end  <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (chars.valid && chars.ready) unescape_step(chars.in_byte, chars.at_end);
      if (!chars.valid || chars.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          chars.valid <= 1'b0;
        end else if (pending.size() != 0) begin
          next_char     = pending.pop_front();
          chars.valid   <= 1'b1;
          chars.in_byte <= next_char.ch;
          chars.at_end  <= next_char.at_end;
          if (!calm && pending.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0)
            send_gap <= $urandom_range(1, 4);
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: stall in short bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
      take_gap      <= 0;
    end else if (take_gap != 0) begin
      take_gap      <= take_gap - 1;
      results.ready <= 1'b0;
    end else if (!calm && pending.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
      take_gap      <= $urandom_range(0, 3);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each beat with the oldest decoded beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      got_beat.out_byte = results.out_byte;
      got_beat.kind     = results.kind;
      got_beat.last     = results.last;
      if (decoded_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h kind=%0d last=%0b",
                                  got_beat.out_byte, got_beat.kind, got_beat.last));
      end else begin
        want_beat = decoded_beats.pop_front();
        if (got_beat.out_byte !== want_beat.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    got_beat.out_byte, want_beat.out_byte));
        if (got_beat.kind !== want_beat.kind)
          report_mismatch($sformatf("kind %0d, want %0d", got_beat.kind, want_beat.kind));
        if (got_beat.last !== want_beat.last)
          report_mismatch($sformatf("last %0b, want %0b", got_beat.last, want_beat.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up after a long run of cycles with no beat on either side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready)) begin
      idle_cycles <= 0;
    end else if (pending.size() != 0 || decoded_beats.size() != 0 || chars.valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_directed;
    int pick;
    rst           = 1'b1;
    chars.valid   = 1'b0;
    chars.in_byte = 8'h00;
    chars.at_end  = 1'b0;
    results.ready = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    scan_mode     = SCAN_QUOTE;
    hex_count     = '0;
    code_pt       = '0;

    // Directed: stray byte and end mark while waiting for a quote
    push_str("x");
    push_end();
    // Extreme plain bytes, a quote escape, \u0000 and the largest code point
    push_str("\"");
    push_char(8'h00);
    push_char(8'hff);
    push_str("\\\"");
    push_str("\\u0000");
    push_str("\\uFffF");
    push_str("\"");
    // Unknown escape letter, non-hex digit, end of input inside a string
    push_str("\"\\q");
    push_str("\"\\ug");
    push_str("\"a");
    push_end();
    n_directed = pending.size();

    // Random: mostly well-formed strings, some broken ones and noise
    while (pending.size() < n_directed + NUM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) push_end();
          else push_char(8'($urandom_range(0, 255)));
        end
      end else begin
        push_string(pick <= 2);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || chars.valid || decoded_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && decoded_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/jsu_pkg.sv
src/jsu_char_if.sv
src/jsu_result_if.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_core.sv
tb/tb_json_string_unescape_core.sv
